// ===== hw/rtl/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// plr_pkg
// Shared types and constants of the piecewise linear recoder.
// ----------------------------------------------------------------------------
package plr_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;
    localparam int QUO_W      = VAL_W + 1;
    localparam int PROD_W     = VAL_W + QUO_W;
    localparam int STEP_W     = 6;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    // words of one block
    localparam logic [1:0] W_FS = 2'd0;
    localparam logic [1:0] W_FE = 2'd1;
    localparam logic [1:0] W_TS = 2'd2;
    localparam logic [1:0] W_TE = 2'd3;

    // register index (paddr[2])
    localparam logic REG_BLOCK_COUNT = 1'b0;

    // sample token handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic                    interp;
        logic                    neg;
        logic                    xu;
        logic signed [VAL_W-1:0] x;
        logic [VAL_W-1:0]        a;
        logic [QUO_W-1:0]        d;
        logic [VAL_W-1:0]        span;
    } t_tok;

    // table write broadcast to the cells
    typedef struct packed {
        logic [1:0]              word;
        logic signed [VAL_W-1:0] value;
        logic                    undef;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_HOLD
    } t_state;

endpackage

// ===== hw/rtl/plr_in_if.sv =====
// ----------------------------------------------------------------------------
// plr_in_if
// Input channel: samples and table writes.
// ----------------------------------------------------------------------------
interface plr_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic signed [31:0] sample_value;
    logic        sample_undefined;
    logic [2:0]  block_index;
    logic [1:0]  block_word;

    modport source (output valid, kind, sample_value, sample_undefined,
                    block_index, block_word, input ready);
    modport sink   (input valid, kind, sample_value, sample_undefined,
                    block_index, block_word, output ready);
endinterface

// ===== hw/rtl/plr_out_if.sv =====
// ----------------------------------------------------------------------------
// plr_out_if
// Output channel: recoded samples.
// ----------------------------------------------------------------------------
interface plr_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] out_value;
    logic        out_undefined;

    modport source (output valid, out_value, out_undefined, input ready);
    modport sink   (input valid, out_value, out_undefined, output ready);
endinterface

// ===== hw/rtl/piecewise_linear_recode.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_recode
// Recodes Q16.16 samples through a chain of range block cells.
//
//  channel  dir  handshake         carries
//  i_in     in   valid/ready       kind, sample_value, sample_undefined,
//                                  block_index, block_word
//  o_out    out  valid/ready       out_value, out_undefined
//  apb      in   psel/penable      block_count at address 0
//
// A table write is stored at accept. A sample walks the MAX_BLOCKS cells, one
// cell per cycle, then the end stage, where an interpolating sample passes a
// multiply step, a 33-step divider and a sum step before its result is held.
// One sample is in flight at a time; the next item is taken once the
// result sits in the output register, even while that waits on o_out.ready.
// Reset is synchronous, active low; the block table holds no reset value.
// ----------------------------------------------------------------------------
module piecewise_linear_recode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    plr_in_if.sink                           i_in,
    plr_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [plr_pkg::ADDR_W-1:0]       paddr,
    input  logic [plr_pkg::DATA_W-1:0]       pwdata,
    output logic [plr_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import plr_pkg::*;

    logic [CNT_W-1:0]        r_bc;
    logic                    r_busy;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_undef;

    logic                    w_acc;
    logic                    w_out_free;
    logic [CNT_W-1:0]        w_neff;
    t_tok                    w_tok [MAX_BLOCKS+1];
    t_wr                     w_wr;
    logic [MAX_BLOCKS-1:0]   w_chain_v;
    logic                    w_res_valid;
    logic signed [VAL_W-1:0] w_res_value;
    logic                    w_res_undef;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? DATA_W'(r_bc) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= CNT_W'(1);
        end else if (psel && penable && pwrite && paddr[2] == REG_BLOCK_COUNT) begin
            r_bc <= pwdata[CNT_W-1:0];
        end
    end

    // blocks in use, clamped
    always_comb begin
        if (r_bc == '0) begin
            w_neff = CNT_W'(1);
        end else if (r_bc > CNT_W'(MAX_BLOCKS)) begin
            w_neff = CNT_W'(MAX_BLOCKS);
        end else begin
            w_neff = r_bc;
        end
    end

    // input item acceptance and token injection
    assign i_in.ready = !r_busy;
    assign w_acc      = i_in.valid && !r_busy;

    assign w_wr.word  = i_in.block_word;
    assign w_wr.value = i_in.sample_value;
    assign w_wr.undef = i_in.sample_undefined;

    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].valid  = w_acc && (i_in.kind == KIND_SAMPLE);
        w_tok[0].x      = i_in.sample_value;
        w_tok[0].xu     = i_in.sample_undefined;
    end

    // chain of range block cells
    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        plr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (CNT_W'(k) < w_neff),
            .i_we     (w_acc && i_in.kind == KIND_WRITE
                       && i_in.block_index == IDX_W'(k)),
            .i_wr     (w_wr),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
        assign w_chain_v[k] = w_tok[k+1].valid;
    end

    plr_interp u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok[MAX_BLOCKS]),
        .i_take      (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res_value (w_res_value),
        .o_res_undef (w_res_undef)
    );

    // busy from sample accept until its result is in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_busy <= 1'b0;
        end else if (w_acc && i_in.kind == KIND_SAMPLE) begin
            r_busy <= 1'b1;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
        if (w_out_free && w_res_valid) begin
            r_out_value <= w_res_value;
            r_out_undef <= w_res_undef;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_value     = r_out_value;
    assign o_out.out_undefined = r_out_undef;

    // checks
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_chain_v) <= 1)
        else $error("more than one sample token in the chain");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chain_v != '0) |-> r_busy)
        else $error("token in chain while idle");

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.kind == KIND_SAMPLE) |=> r_busy)
        else $error("sample accepted but block not busy");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_undefined) |-> (o_out.out_value == '0))
        else $error("undefined result with nonzero value");

endmodule

// ===== hw/rtl/plr_cell.sv =====
// ----------------------------------------------------------------------------
// plr_cell
// One range block: holds its four words and checks the passing sample token.
// ----------------------------------------------------------------------------
module plr_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_active,
    input  logic          i_we,
    input  plr_pkg::t_wr  i_wr,
    input  plr_pkg::t_tok i_tok,
    output plr_pkg::t_tok o_tok
);
    import plr_pkg::*;

    logic signed [VAL_W-1:0] r_val [4];
    logic                    r_und [4];
    t_tok                    r_tok;
    t_tok                    n_tok;

    logic signed [VAL_W:0]   w_a;
    logic signed [VAL_W:0]   w_span;
    logic signed [VAL_W:0]   w_dt;
    logic [QUO_W-1:0]        w_dabs;
    logic                    w_in_rng;
    logic                    w_to_zero;

    // block words, written by table write items
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_val[i_wr.word] <= i_wr.value;
            r_und[i_wr.word] <= i_wr.undef;
        end
    end

    // differences for the interpolation operands
    assign w_a    = {i_tok.x[VAL_W-1], i_tok.x} - {r_val[W_FS][VAL_W-1], r_val[W_FS]};
    assign w_span = {r_val[W_FE][VAL_W-1], r_val[W_FE]}
                  - {r_val[W_FS][VAL_W-1], r_val[W_FS]};
    assign w_dt   = {r_val[W_TE][VAL_W-1], r_val[W_TE]}
                  - {r_val[W_TS][VAL_W-1], r_val[W_TS]};
    assign w_dabs = w_dt[VAL_W] ? QUO_W'(-w_dt) : QUO_W'(w_dt);

    assign w_in_rng  = !i_tok.xu && !r_und[W_FS] && !r_und[W_FE]
                     && (i_tok.x >= r_val[W_FS]) && (i_tok.x <= r_val[W_FE]);
    assign w_to_zero = !r_und[W_TS] && !r_und[W_TE] && (r_val[W_TS] == r_val[W_TE]);

    // block check
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.done && i_active) begin
            if (r_und[W_FS] && i_tok.xu) begin
                n_tok.x  = r_val[W_TS];
                n_tok.xu = r_und[W_TS];
            end else if (w_in_rng) begin
                n_tok.done = 1'b1;
                if ((r_val[W_FS] == r_val[W_FE]) || w_to_zero) begin
                    n_tok.x  = r_val[W_TS];
                    n_tok.xu = r_und[W_TS];
                end else if (r_und[W_TS] || r_und[W_TE]) begin
                    n_tok.xu = 1'b1;
                end else begin
                    n_tok.interp = 1'b1;
                    n_tok.x      = r_val[W_TS];
                    n_tok.a      = w_a[VAL_W-1:0];
                    n_tok.span   = w_span[VAL_W-1:0];
                    n_tok.d      = w_dabs;
                    n_tok.neg    = w_dt[VAL_W];
                end
            end
        end
    end

    // token register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.done   <= n_tok.done;
        r_tok.interp <= n_tok.interp;
        r_tok.neg    <= n_tok.neg;
        r_tok.xu     <= n_tok.xu;
        r_tok.x      <= n_tok.x;
        r_tok.a      <= n_tok.a;
        r_tok.d      <= n_tok.d;
        r_tok.span   <= n_tok.span;
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/plr_interp.sv =====
// ----------------------------------------------------------------------------
// plr_interp
// End of the chain: multiply, bit-serial divide, offset and saturate, or hold a finished value.
// ----------------------------------------------------------------------------
module plr_interp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  plr_pkg::t_tok                  i_tok,
    input  logic                           i_take,
    output logic                           o_res_valid,
    output logic signed [plr_pkg::VAL_W-1:0] o_res_value,
    output logic                           o_res_undef
);
    import plr_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [VAL_W-1:0]        r_a;
    logic [QUO_W-1:0]        r_d;
    logic [VAL_W-1:0]        r_span;
    logic signed [VAL_W-1:0] r_ts;
    logic                    r_neg;
    logic [VAL_W:0]          r_rem;
    logic [QUO_W-1:0]        r_low;
    logic [QUO_W-1:0]        r_q;
    logic [STEP_W-1:0]       r_step;
    logic signed [VAL_W-1:0] r_res;
    logic                    r_res_u;

    logic [2*VAL_W-1:0]      w_mul;
    logic [PROD_W-1:0]       w_prod;
    logic [VAL_W:0]          w_trial;
    logic                    w_qbit;
    logic signed [VAL_W+1:0] w_sum;
    logic                    w_last;

    localparam logic signed [VAL_W+1:0] SAT_MAX = $signed({3'b000, {(VAL_W-1){1'b1}}});
    localparam logic signed [VAL_W+1:0] SAT_MIN = $signed({3'b111, {(VAL_W-1){1'b0}}});

    // 32x32 product plus the top bit of the to-range difference as a shifted add
    assign w_mul  = r_a * r_d[VAL_W-1:0];
    assign w_prod = {1'b0, w_mul}
                  + (r_d[VAL_W] ? {1'b0, r_a, {VAL_W{1'b0}}} : '0);

    // one restoring division step
    assign w_trial = {r_rem[VAL_W-1:0], r_low[QUO_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_span});
    assign w_last  = (r_step == STEP_W'(QUO_W - 1));

    // offset by the to-start word
    assign w_sum = r_neg ? ({{2{r_ts[VAL_W-1]}}, r_ts} - {1'b0, r_q})
                         : ({{2{r_ts[VAL_W-1]}}, r_ts} + {1'b0, r_q});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_tok.valid) begin
                n_state = i_tok.interp ? ST_MUL : ST_HOLD;
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (w_last) begin
                n_state = ST_SUM;
            end
            ST_SUM:  n_state = ST_HOLD;
            ST_HOLD: if (i_take) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_res_valid = (r_state == ST_HOLD);
        o_res_value = r_res;
        o_res_undef = r_res_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_a     <= i_tok.a;
                r_d     <= i_tok.d;
                r_span  <= i_tok.span;
                r_ts    <= i_tok.x;
                r_neg   <= i_tok.neg;
                r_res   <= i_tok.xu ? '0 : i_tok.x;
                r_res_u <= i_tok.xu;
            end
            ST_MUL: begin
                r_rem  <= {1'b0, w_prod[PROD_W-1:QUO_W]};
                r_low  <= w_prod[QUO_W-1:0];
                r_step <= '0;
                r_q    <= '0;
            end
            ST_DIV: begin
                r_rem  <= w_qbit ? (w_trial - {1'b0, r_span}) : w_trial;
                r_low  <= {r_low[QUO_W-2:0], 1'b0};
                r_q    <= {r_q[QUO_W-2:0], w_qbit};
                r_step <= r_step + 1'b1;
            end
            ST_SUM: begin
                r_res_u <= 1'b0;
                if (w_sum > SAT_MAX) begin
                    r_res <= SAT_MAX[VAL_W-1:0];
                end else if (w_sum < SAT_MIN) begin
                    r_res <= SAT_MIN[VAL_W-1:0];
                end else begin
                    r_res <= w_sum[VAL_W-1:0];
                end
            end
            ST_HOLD: begin
                r_res <= r_res;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

endmodule
